// File: design/mct_pkg.sv
// Package for the minute countdown timer with alarm.
// Widths, mode/LED/key codes, reset values and the shared structs.
// No dependencies.
package mct_pkg;

    localparam int TPS_W  = 16;
    localparam int MIN_W  = 7;
    localparam int SEC_W  = 13;
    localparam int SS_W   = 6;
    localparam int MODE_W = 2;
    localparam int LED_W  = 2;
    localparam int KEY_W  = 2;
    localparam int ADDR_W = 2;
    localparam int DATA_W = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_SETTING  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNTING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALARM    = 2'd2;

    localparam logic [LED_W-1:0] LED_GREEN  = 2'd0;
    localparam logic [LED_W-1:0] LED_YELLOW = 2'd1;
    localparam logic [LED_W-1:0] LED_RED    = 2'd2;

    localparam logic [KEY_W-1:0] KEY_MINUS = 2'd0;
    localparam logic [KEY_W-1:0] KEY_PLUS  = 2'd1;
    localparam logic [KEY_W-1:0] KEY_SHORT = 2'd2;
    localparam logic [KEY_W-1:0] KEY_LONG  = 2'd3;

    localparam logic [ADDR_W-1:0] REG_TPS     = 2'd0;
    localparam logic [ADDR_W-1:0] REG_BEEP_ON = 2'd1;
    localparam logic [ADDR_W-1:0] REG_PERIOD  = 2'd2;
    localparam logic [ADDR_W-1:0] REG_MAX_MIN = 2'd3;

    localparam logic [TPS_W-1:0] TPS_RST     = 16'd1000;
    localparam logic [TPS_W-1:0] BEEP_ON_RST = 16'd500;
    localparam logic [TPS_W-1:0] PERIOD_RST  = 16'd1000;
    localparam logic [MIN_W-1:0] MAX_MIN_RST = 7'd99;

    typedef struct packed {
        logic [TPS_W-1:0] ticks_per_second;
        logic [TPS_W-1:0] beep_on_ticks;
        logic [TPS_W-1:0] beep_period_ticks;
        logic [MIN_W-1:0] max_minutes;
    } cfg_t;

    typedef struct packed {
        logic              page_exit;
        logic [LED_W-1:0]  led_color;
        logic              beeper_on;
        logic [SEC_W-1:0]  remaining_total;
        logic [MIN_W-1:0]  minutes_set;
        logic [MODE_W-1:0] mode;
    } result_t;

endpackage

// File: design/mct_core.sv
// Timer state and per-item update for the minute countdown timer.
// Depends on mct_pkg.
module mct_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mct_pkg::cfg_t               cfg,
    input  logic                        step,
    input  logic                        action,
    input  logic [mct_pkg::KEY_W-1:0]   key_code,
    output mct_pkg::result_t            res
);
    import mct_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [MIN_W-1:0]  minutes_reg, minutes_next;
    logic [SEC_W-1:0]  secs_reg, secs_next;
    logic [TPS_W-1:0]  pres_reg, pres_next;
    logic [TPS_W-1:0]  phase_reg, phase_next;
    logic              buzzer_reg, buzzer_next;
    logic [LED_W-1:0]  led_reg, led_next;
    logic              exit_flag;
    logic [TPS_W-1:0]  pres_inc, phase_inc;
    logic [SEC_W-1:0]  secs_dec, start_secs;
    logic              busy;

    assign pres_inc   = pres_reg + 1'b1;
    assign phase_inc  = phase_reg + 1'b1;
    assign secs_dec   = (secs_reg != '0) ? secs_reg - 1'b1 : secs_reg;
    assign start_secs = {minutes_reg, 6'd0} - {4'd0, minutes_reg, 2'd0};
    assign busy       = (mode_reg == MODE_COUNTING) || (mode_reg == MODE_ALARM);

    always_comb
    begin
        mode_next    = mode_reg;
        minutes_next = minutes_reg;
        secs_next    = secs_reg;
        pres_next    = pres_reg;
        phase_next   = phase_reg;
        buzzer_next  = buzzer_reg;
        led_next     = led_reg;
        exit_flag    = 1'b0;
        if (!action)
        begin
            case (mode_reg)
                MODE_COUNTING:
                begin
                    if (pres_inc >= cfg.ticks_per_second)
                    begin
                        pres_next = '0;
                        secs_next = secs_dec;
                        if (secs_dec == '0)
                        begin
                            mode_next = MODE_ALARM;
                            led_next  = LED_RED;
                        end
                    end
                    else
                    begin
                        pres_next = pres_inc;
                    end
                end
                MODE_ALARM:
                begin
                    if (phase_inc < cfg.beep_on_ticks)
                    begin
                        phase_next  = phase_inc;
                        buzzer_next = 1'b1;
                    end
                    else if (phase_inc < cfg.beep_period_ticks)
                    begin
                        phase_next  = phase_inc;
                        buzzer_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = '0;
                    end
                end
                default:
                begin
                    pres_next   = '0;
                    phase_next  = '0;
                    buzzer_next = 1'b0;
                end
            endcase
        end
        else if (busy)
        begin
            if (key_code == KEY_SHORT)
                exit_flag = 1'b1;
        end
        else
        begin
            case (key_code)
                KEY_MINUS:
                begin
                    if (minutes_reg > 7'd1)
                        minutes_next = minutes_reg - 1'b1;
                end
                KEY_PLUS:
                begin
                    if (minutes_reg < cfg.max_minutes)
                        minutes_next = minutes_reg + 1'b1;
                end
                KEY_SHORT:
                begin
                    secs_next = start_secs;
                    mode_next = MODE_COUNTING;
                    led_next  = LED_YELLOW;
                end
                default:
                begin
                    exit_flag = 1'b1;
                end
            endcase
        end
        if (exit_flag)
        begin
            mode_next    = MODE_SETTING;
            minutes_next = 7'd1;
            secs_next    = '0;
            buzzer_next  = 1'b0;
            led_next     = LED_GREEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SETTING;
            minutes_reg <= 7'd1;
            secs_reg    <= '0;
            pres_reg    <= '0;
            phase_reg   <= '0;
            buzzer_reg  <= 1'b0;
            led_reg     <= LED_GREEN;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            minutes_reg <= minutes_next;
            secs_reg    <= secs_next;
            pres_reg    <= pres_next;
            phase_reg   <= phase_next;
            buzzer_reg  <= buzzer_next;
            led_reg     <= led_next;
        end
    end

    always_comb
    begin
        res.mode            = mode_next;
        res.minutes_set     = minutes_next;
        res.remaining_total = secs_next;
        res.beeper_on       = buzzer_next;
        res.led_color       = led_next;
        res.page_exit       = exit_flag;
    end

endmodule

// File: design/mct_sec_split.sv
// Splits a seconds count into minutes and seconds for display.
// Divide by 60 through a reciprocal multiply, exact below 7680. Depends on mct_pkg.
module mct_sec_split (
    input  logic [mct_pkg::SEC_W-1:0] total,
    output logic [mct_pkg::MIN_W-1:0] minutes,
    output logic [mct_pkg::SS_W-1:0]  seconds
);
    import mct_pkg::*;

    localparam int RECIP_SH = 19;
    localparam logic [13:0] RECIP = 14'd8739;

    logic [SEC_W+13:0] prod;
    logic [SEC_W-1:0]  q_ext, q_times60, rem;

    assign prod      = total * RECIP;
    assign minutes   = prod[RECIP_SH +: MIN_W];
    assign q_ext     = {{(SEC_W-MIN_W){1'b0}}, minutes};
    assign q_times60 = {q_ext[SEC_W-7:0], 6'd0} - {q_ext[SEC_W-3:0], 2'd0};
    assign rem       = total - q_times60;
    assign seconds   = rem[SS_W-1:0];

endmodule

// File: design/minute_countdown_timer_with_alarm_unit.sv
// Top level of the minute countdown timer with alarm: input register,
// state update, result register and display split. Depends on mct_pkg,
// mct_core and mct_sec_split.
//
// Usage:
//   Input items on s_axis: tuser is the action (0 one ms tick, 1 key press),
//   tdata[1:0] the key code (minus, plus, short select, long select).
//   Each item yields exactly one result on m_axis with mode, minutes set,
//   seconds left with its minute/second split, buzzer, LED and page exit.
//   m_axis_tvalid rises once the item has passed the input register and
//   the state update has loaded the result register.
//   Throughput is one item per cycle while m_axis_tready is high.
//   When the receiver stalls, the result register holds its item and one
//   more item can wait in the input register; then s_axis_tready drops.
//   Reset gives setting mode, 1 minute, 0 s, buzzer off, LED green, and
//   the configuration registers take their default values.
//   Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once;
//   the user makes them only while the block is idle; it does not enforce this.
module minute_countdown_timer_with_alarm_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mct_pkg::ADDR_W-1:0]         cfg_addr,
    input  logic [mct_pkg::DATA_W-1:0]         cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mct_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // key_code[1:0], zeros
    input  logic                               s_axis_tuser,  // action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mct_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
    // m_axis_tdata: mode[1:0], minutes_set[8:2], remaining_total[21:9],
    // remaining_minutes[28:22], remaining_seconds[34:29], beeper_on[35],
    // led_color[37:36], page_exit[38], zero[39]
);
    import mct_pkg::*;

    cfg_t             cfg_reg;
    logic             in_vld_reg;
    logic             in_action_reg;
    logic [KEY_W-1:0] in_key_reg;
    logic             out_vld_reg;
    result_t          out_reg;
    result_t          core_res;
    logic             advance;
    logic [MIN_W-1:0] disp_min;
    logic [SS_W-1:0]  disp_sec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second  <= TPS_RST;
            cfg_reg.beep_on_ticks     <= BEEP_ON_RST;
            cfg_reg.beep_period_ticks <= PERIOD_RST;
            cfg_reg.max_minutes       <= MAX_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TPS:     cfg_reg.ticks_per_second  <= cfg_wdata;
                REG_BEEP_ON: cfg_reg.beep_on_ticks     <= cfg_wdata;
                REG_PERIOD:  cfg_reg.beep_period_ticks <= cfg_wdata;
                REG_MAX_MIN: cfg_reg.max_minutes       <= cfg_wdata[MIN_W-1:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_vld_reg <= s_axis_tvalid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_action_reg <= s_axis_tuser;
            in_key_reg    <= s_axis_tdata[KEY_W-1:0];
        end
        if (advance)
            out_reg <= core_res;
    end

    mct_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .step     (advance),
        .action   (in_action_reg),
        .key_code (in_key_reg),
        .res      (core_res)
    );

    mct_sec_split u_split (
        .total   (out_reg.remaining_total),
        .minutes (disp_min),
        .seconds (disp_sec)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_reg.page_exit, out_reg.led_color, out_reg.beeper_on,
                            disp_sec, disp_min, out_reg.remaining_total,
                            out_reg.minutes_set, out_reg.mode};

endmodule
